>>> hw/rtl/dmpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpd_pkg: shared types and constants of the page directory
// Word layouts, mode codes, sequencer states and sizing constants.
// ----------------------------------------------------------------------------
package dmpd_pkg;

	localparam int ENTRIES   = 64;
	localparam int IDX_W     = $clog2(ENTRIES);
	localparam int ADDR_W    = 64;
	localparam int TAG_W     = 57;
	localparam int SIZE_W    = 13;
	localparam int OFF_W     = 16;
	localparam int SLOT_W    = 6;
	localparam int CNT_W     = 32;
	localparam int SHIFT_W   = 5;
	localparam int PG_W      = OFF_W + 1;
	localparam int Q_DEPTH   = 2;
	localparam int Q_AW      = $clog2(Q_DEPTH);

	localparam logic [SHIFT_W-1:0] MIN_SHIFT   = 5'd7;
	localparam logic [SHIFT_W-1:0] MAX_SHIFT   = 5'd16;
	localparam logic [SHIFT_W-1:0] RESET_SHIFT = 5'd12;
	localparam logic [SIZE_W-1:0]  MAX_ACCESS  = 13'd4096;

	typedef enum logic [1:0] {
		MODE_DATA    = 2'd0,
		MODE_INSN    = 2'd1,
		MODE_INSTALL = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] address;
		logic [SIZE_W-1:0] access_size;
		logic              is_write;
	} in_word_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic [OFF_W-1:0]  page_offset;
		logic [SIZE_W-1:0] piece_length;
		logic              write_dir;
		logic              last;
		logic [ADDR_W-1:0] miss_address;
		logic [CNT_W-1:0]  hit_count;
		logic [CNT_W-1:0]  miss_count;
	} out_word_t;

	typedef struct packed {
		mode_t              mode;
		logic [ADDR_W-1:0]  addr;
		logic [SIZE_W-1:0]  size;
		logic               wdir;
		logic [SHIFT_W-1:0] shift;
	} cmd_t;

endpackage

>>> hw/rtl/dmpd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpd_front: intake and classification
// Holds the page shift register, clamps shift and size, drops unused modes
// and hands commands to the queue.
// ----------------------------------------------------------------------------
module dmpd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dmpd_pkg::in_word_t   in_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [4:0]           cfg_data,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	output dmpd_pkg::cmd_t       cmd
);

	logic [dmpd_pkg::SHIFT_W-1:0] shift_cfg_q;
	logic [dmpd_pkg::SHIFT_W-1:0] shift_eff;
	dmpd_pkg::mode_t              mode_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cfg_q <= dmpd_pkg::RESET_SHIFT;
		end else if (cfg_valid && cfg_ready) begin
			shift_cfg_q <= cfg_data;
		end
	end

	always_comb begin
		priority if (shift_cfg_q < dmpd_pkg::MIN_SHIFT) begin
			shift_eff = dmpd_pkg::MIN_SHIFT;
		end else if (shift_cfg_q > dmpd_pkg::MAX_SHIFT) begin
			shift_eff = dmpd_pkg::MAX_SHIFT;
		end else begin
			shift_eff = shift_cfg_q;
		end
	end

	assign mode_in = dmpd_pkg::mode_t'(in_word.mode);

	always_comb begin
		cmd.mode  = mode_in;
		cmd.addr  = in_word.address;
		cmd.size  = (in_word.access_size > dmpd_pkg::MAX_ACCESS) ?
			dmpd_pkg::MAX_ACCESS : in_word.access_size;
		cmd.wdir  = in_word.is_write;
		cmd.shift = shift_eff;
	end

	// drop unused-mode words at the door
	assign cmd_valid = in_valid && (mode_in != dmpd_pkg::MODE_NONE);
	assign in_ready  = cmd_ready;

endmodule

>>> hw/rtl/dmpd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpd_fifo: command queue
// Short queue that decouples intake from the lookup sequencer.
// ----------------------------------------------------------------------------
module dmpd_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  dmpd_pkg::cmd_t   push_cmd,
	output logic             pop_valid,
	input  logic             pop_ready,
	output dmpd_pkg::cmd_t   pop_cmd
);

	dmpd_pkg::cmd_t                mem_q [dmpd_pkg::Q_DEPTH];
	logic [dmpd_pkg::Q_AW-1:0]     wr_ptr_q;
	logic [dmpd_pkg::Q_AW-1:0]     rd_ptr_q;
	logic [dmpd_pkg::Q_AW:0]       count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = (count_q != (dmpd_pkg::Q_AW+1)'(dmpd_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == dmpd_pkg::Q_AW'(dmpd_pkg::Q_DEPTH-1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == dmpd_pkg::Q_AW'(dmpd_pkg::Q_DEPTH-1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> hw/rtl/dmpd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmpd_back: lookup sequencer
// Owns the tag memory, valid bits, counters and miss address. Walks each
// command piece by piece and fills the output register.
// ----------------------------------------------------------------------------
module dmpd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  dmpd_pkg::cmd_t       cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dmpd_pkg::out_word_t  out_word
);

	dmpd_pkg::state_t               state_q;
	dmpd_pkg::state_t               state_nx;

	logic [dmpd_pkg::TAG_W-1:0]     tag_mem [dmpd_pkg::ENTRIES];
	logic [dmpd_pkg::ENTRIES-1:0]   tag_vld_q;
	logic [dmpd_pkg::TAG_W-1:0]     rd_tag_q;
	logic                           vld_rd_q;

	dmpd_pkg::mode_t                cur_mode_q;
	logic [dmpd_pkg::ADDR_W-1:0]    cur_addr_q;
	logic [dmpd_pkg::SIZE_W-1:0]    cur_size_q;
	logic                           cur_wdir_q;
	logic [dmpd_pkg::SHIFT_W-1:0]   cur_shift_q;
	logic [dmpd_pkg::TAG_W-1:0]     page_q;

	logic [dmpd_pkg::CNT_W-1:0]     hits_q;
	logic [dmpd_pkg::CNT_W-1:0]     misses_q;
	logic [dmpd_pkg::ADDR_W-1:0]    last_miss_q;

	logic                           out_valid_q;
	dmpd_pkg::out_word_t            out_q;

	logic [dmpd_pkg::TAG_W-1:0]     page_now;
	logic [dmpd_pkg::IDX_W-1:0]     rd_idx;
	logic [dmpd_pkg::IDX_W-1:0]     cur_idx;
	logic [dmpd_pkg::PG_W-1:0]      pg;
	logic [dmpd_pkg::OFF_W-1:0]     off_mask;
	logic [dmpd_pkg::OFF_W-1:0]     off;
	logic [dmpd_pkg::PG_W-1:0]      room;
	logic [dmpd_pkg::SIZE_W-1:0]    remain;
	logic [dmpd_pkg::SIZE_W-1:0]    size_nx;
	logic                           tag_hit;
	logic                           piece_last;
	logic [dmpd_pkg::CNT_W-1:0]     hits_nx;
	logic [dmpd_pkg::CNT_W-1:0]     misses_nx;
	logic [dmpd_pkg::ADDR_W-1:0]    miss_nx;
	dmpd_pkg::out_word_t            res;

	logic                           emit_ok;
	logic                           mem_re;
	logic                           mem_we;
	logic                           do_emit;

	assign out_valid = out_valid_q;
	assign out_word  = out_q;
	assign emit_ok   = !out_valid_q || out_ready;

	assign page_now = dmpd_pkg::TAG_W'(cur_addr_q >> cur_shift_q);
	assign rd_idx   = page_now[dmpd_pkg::IDX_W-1:0];
	assign cur_idx  = page_q[dmpd_pkg::IDX_W-1:0];

	// piece arithmetic and result assembly
	always_comb begin
		pg       = dmpd_pkg::PG_W'(1) << cur_shift_q;
		off_mask = dmpd_pkg::OFF_W'(pg - dmpd_pkg::PG_W'(1));
		off      = cur_addr_q[dmpd_pkg::OFF_W-1:0] & off_mask;
		room     = pg - dmpd_pkg::PG_W'(off);
		remain   = (room > dmpd_pkg::PG_W'(cur_size_q)) ?
			cur_size_q : dmpd_pkg::SIZE_W'(room);
		size_nx  = cur_size_q - remain;
		tag_hit  = vld_rd_q && (rd_tag_q == page_q);

		hits_nx    = hits_q;
		misses_nx  = misses_q;
		miss_nx    = last_miss_q;
		piece_last = 1'b1;
		res        = '0;
		res.slot   = dmpd_pkg::SLOT_W'(cur_idx);

		unique case (cur_mode_q)
			dmpd_pkg::MODE_DATA: begin
				res.hit          = tag_hit;
				res.page_offset  = off;
				res.piece_length = remain;
				res.write_dir    = cur_wdir_q;
				if (tag_hit) begin
					hits_nx    = hits_q + 1'b1;
					piece_last = (size_nx == '0);
				end else begin
					misses_nx = misses_q + 1'b1;
					miss_nx   = cur_addr_q;
				end
			end
			dmpd_pkg::MODE_INSN: begin
				res.hit         = tag_hit;
				res.page_offset = off >> 1;
				if (!tag_hit) begin
					miss_nx = cur_addr_q;
				end
			end
			dmpd_pkg::MODE_INSTALL: begin
				res.hit = 1'b1;
			end
			default: begin
				res.hit = 1'b0;
			end
		endcase

		res.last         = piece_last;
		res.miss_address = miss_nx;
		res.hit_count    = hits_nx;
		res.miss_count   = misses_nx;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dmpd_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_nx = dmpd_pkg::ST_READ;
				end
			end
			dmpd_pkg::ST_READ: begin
				state_nx = dmpd_pkg::ST_EMIT;
			end
			dmpd_pkg::ST_EMIT: begin
				if (emit_ok) begin
					state_nx = piece_last ? dmpd_pkg::ST_IDLE : dmpd_pkg::ST_READ;
				end
			end
			default: begin
				state_nx = dmpd_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		cmd_ready = (state_q == dmpd_pkg::ST_IDLE);
		mem_re    = (state_q == dmpd_pkg::ST_READ);
		do_emit   = (state_q == dmpd_pkg::ST_EMIT) && emit_ok;
		mem_we    = do_emit && (cur_mode_q == dmpd_pkg::MODE_INSTALL);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[cur_idx] <= page_q;
		end
		if (mem_re) begin
			rd_tag_q <= tag_mem[rd_idx];
			vld_rd_q <= tag_vld_q[rd_idx];
			page_q   <= page_now;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cur_mode_q  <= cmd.mode;
			cur_addr_q  <= cmd.addr;
			cur_size_q  <= cmd.size;
			cur_wdir_q  <= cmd.wdir;
			cur_shift_q <= cmd.shift;
		end else if (do_emit) begin
			cur_addr_q <= cur_addr_q + dmpd_pkg::ADDR_W'(remain);
			cur_size_q <= size_nx;
		end
		if (do_emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmpd_pkg::ST_IDLE;
			tag_vld_q   <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			last_miss_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (mem_we) begin
				tag_vld_q[cur_idx] <= 1'b1;
			end
			if (do_emit) begin
				hits_q      <= hits_nx;
				misses_q    <= misses_nx;
				last_miss_q <= miss_nx;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hw/rtl/direct_mapped_page_directory_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_page_directory_core: page directory tag lookup
// Direct-mapped page tag directory with data access splitting, instruction
// lookup, tag install, hit and miss counters and miss address capture.
//
//   channel  dir  payload              handshake
//   in       in   in_word_t            in_valid / in_ready
//   out      out  out_word_t           out_valid / out_ready
//   cfg      in   log2 page, 5 bits    cfg_valid / cfg_ready
//
// A single-piece word passes through the sequencer steps dequeue, tag read,
// and compare and emit; each further page piece goes back through the registered
// tag memory read and the emit step. The intake queues up to 2 words ahead.
// After reset all tags are invalid at once through per-slot valid bits.
// A stalled output register holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
module direct_mapped_page_directory_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dmpd_pkg::in_word_t   in_word,
	output logic                 out_valid,
	input  logic                 out_ready,
	output dmpd_pkg::out_word_t  out_word,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [4:0]           cfg_data
);

	logic            push_valid;
	logic            push_ready;
	dmpd_pkg::cmd_t  push_cmd;
	logic            pop_valid;
	logic            pop_ready;
	dmpd_pkg::cmd_t  pop_cmd;

	dmpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd_valid (push_valid),
		.cmd_ready (push_ready),
		.cmd       (push_cmd)
	);

	dmpd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	dmpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

	a_no_unused_mode_queued: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> push_cmd.mode != dmpd_pkg::MODE_NONE)
		else $error("unused mode word entered the queue");

	a_queue_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && !pop_ready |=> pop_valid && $stable(pop_cmd))
		else $error("queue head changed while waiting");

	a_miss_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && !out_word.hit |-> out_word.last)
		else $error("miss word without last");

	a_piece_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.piece_length <= dmpd_pkg::MAX_ACCESS)
		else $error("piece longer than the access limit");

endmodule

>>> sim/direct_mapped_page_directory_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_page_directory_checker: result predictor and scoreboard
// Watches the configuration, input and output channels of the page
// directory. Each accepted input word is resolved against a private copy of
// the tag directory, counters, miss address and page shift. This gives the
// result words the block owes. Each accepted output word is compared field by
// field with the oldest one still owed.
// ----------------------------------------------------------------------------
module direct_mapped_page_directory_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  dmpd_pkg::in_word_t   in_word,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  dmpd_pkg::out_word_t  out_word,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [4:0]           cfg_data,
	output int                   fail_count,
	output int                   outstanding
);

	localparam int MAX_PIECES = 33;

	logic [dmpd_pkg::TAG_W-1:0]   tag_mem [dmpd_pkg::ENTRIES];
	logic                         tag_ok [dmpd_pkg::ENTRIES];
	logic [dmpd_pkg::CNT_W-1:0]   hit_tally;
	logic [dmpd_pkg::CNT_W-1:0]   miss_tally;
	logic [dmpd_pkg::ADDR_W-1:0]  last_miss_addr;
	logic [dmpd_pkg::SHIFT_W-1:0] shift_q;
	dmpd_pkg::out_word_t          owed_q[$];

	function automatic dmpd_pkg::out_word_t with_totals(dmpd_pkg::out_word_t r);
		r.miss_address = last_miss_addr;
		r.hit_count = hit_tally;
		r.miss_count = miss_tally;
		return r;
	endfunction

	task automatic resolve_word(input dmpd_pkg::in_word_t w);
		logic [dmpd_pkg::SHIFT_W-1:0] sh;
		logic [63:0]                  pg;
		logic [63:0]                  addr;
		logic [63:0]                  off;
		logic [63:0]                  size;
		logic [63:0]                  remain;
		logic [63:0]                  pn;
		logic [dmpd_pkg::IDX_W-1:0]   s;
		logic                         hit;
		logic                         done;
		int                           k;
		dmpd_pkg::out_word_t          r;
		sh = (shift_q < dmpd_pkg::MIN_SHIFT) ? dmpd_pkg::MIN_SHIFT :
			(shift_q > dmpd_pkg::MAX_SHIFT) ? dmpd_pkg::MAX_SHIFT : shift_q;
		pg = 64'd1 << sh;
		addr = w.address;
		pn = addr >> sh;
		s = pn[dmpd_pkg::IDX_W-1:0];
		hit = tag_ok[s] && (tag_mem[s] == pn[dmpd_pkg::TAG_W-1:0]);
		off = addr & (pg - 64'd1);
		r = '0;
		r.slot = s;
		r.last = 1'b1;
		case (w.mode)
			dmpd_pkg::MODE_INSTALL: begin
				tag_mem[s] = pn[dmpd_pkg::TAG_W-1:0];
				tag_ok[s] = 1'b1;
				r.hit = 1'b1;
				owed_q.push_back(with_totals(r));
			end
			dmpd_pkg::MODE_INSN: begin
				if (!hit)
					last_miss_addr = addr;
				r.hit = hit;
				off = off >> 1;
				r.page_offset = off[dmpd_pkg::OFF_W-1:0];
				owed_q.push_back(with_totals(r));
			end
			dmpd_pkg::MODE_DATA: begin
				size = {51'd0, w.access_size};
				if (size > 64'(dmpd_pkg::MAX_ACCESS))
					size = 64'(dmpd_pkg::MAX_ACCESS);
				remain = pg - off;
				if (remain > size)
					remain = size;
				k = 0;
				done = 1'b0;
				do begin
					pn = addr >> sh;
					s = pn[dmpd_pkg::IDX_W-1:0];
					hit = tag_ok[s] && (tag_mem[s] == pn[dmpd_pkg::TAG_W-1:0]);
					off = addr & (pg - 64'd1);
					r = '0;
					r.hit = hit;
					r.slot = s;
					r.page_offset = off[dmpd_pkg::OFF_W-1:0];
					r.piece_length = remain[dmpd_pkg::SIZE_W-1:0];
					r.write_dir = w.is_write;
					if (!hit) begin
						last_miss_addr = addr;
						miss_tally = miss_tally + 1'b1;
						r.last = 1'b1;
						done = 1'b1;
					end else begin
						hit_tally = hit_tally + 1'b1;
						size = size - remain;
						r.last = (size == 64'd0);
						addr = addr + remain;
						remain = (size < pg) ? size : pg;
					end
					owed_q.push_back(with_totals(r));
					k++;
				end while (!done && size != 64'd0 && k < MAX_PIECES);
			end
			default: ;
		endcase
	endtask

	task automatic check_word(input dmpd_pkg::out_word_t got);
		dmpd_pkg::out_word_t exp;
		logic                bad;
		if (owed_q.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: unexpected result word %h", $realtime, got);
		end else begin
			exp = owed_q.pop_front();
			bad = (got.hit !== exp.hit) || (got.slot !== exp.slot) ||
				(got.page_offset !== exp.page_offset) ||
				(got.piece_length !== exp.piece_length) ||
				(got.write_dir !== exp.write_dir) || (got.last !== exp.last) ||
				(got.miss_address !== exp.miss_address) ||
				(got.hit_count !== exp.hit_count) || (got.miss_count !== exp.miss_count);
			if (bad) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("%0t: result mismatch, expected / actual:", $realtime);
					$display("  hit %0d / %0d  slot %0d / %0d  offset %h / %h",
						exp.hit, got.hit, exp.slot, got.slot,
						exp.page_offset, got.page_offset);
					$display("  length %0d / %0d  write %0d / %0d  last %0d / %0d",
						exp.piece_length, got.piece_length, exp.write_dir,
						got.write_dir, exp.last, got.last);
					$display("  miss address %h / %h", exp.miss_address, got.miss_address);
					$display("  hits %0d / %0d  misses %0d / %0d",
						exp.hit_count, got.hit_count, exp.miss_count, got.miss_count);
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < dmpd_pkg::ENTRIES; i++) begin
				tag_mem[i] = '1;
				tag_ok[i] = 1'b0;
			end
			hit_tally = '0;
			miss_tally = '0;
			last_miss_addr = '0;
			shift_q = dmpd_pkg::RESET_SHIFT;
			owed_q.delete();
			fail_count = 0;
		end else begin
			// a word taken at this edge still sees the old shift
			if (in_valid && in_ready)
				resolve_word(in_word);
			if (cfg_valid && cfg_ready)
				shift_q = cfg_data;
			if (out_valid && out_ready)
				check_word(out_word);
		end
		outstanding = owed_q.size();
	end

endmodule

>>> sim/direct_mapped_page_directory_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_page_directory_core_tb: page directory testbench
// Drives directed and random words into the page directory across several
// page shift settings and idle patterns on both channels. A side checker
// predicts and compares every result word; this top gives the verdict.
// ----------------------------------------------------------------------------
module direct_mapped_page_directory_core_tb;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 32;
	localparam int PHASES = 6;
	localparam int PHASE_WORDS = 54;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_ready;
	dmpd_pkg::in_word_t           in_word;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	dmpd_pkg::out_word_t          out_word;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [4:0]                   cfg_data;
	int                           fail_count;
	int                           outstanding;
	int                           snd_idle;
	int                           rcv_idle;
	int                           cycle_count = 0;
	logic [dmpd_pkg::SHIFT_W-1:0] cur_shift;
	logic [63:0]                  hot_base [4];
	logic [dmpd_pkg::SHIFT_W-1:0] shift_plan [PHASES] =
		'{5'd7, 5'd16, 5'd31, 5'd0, 5'd9, 5'd13};

	direct_mapped_page_directory_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	direct_mapped_page_directory_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_word    (out_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic issue(input dmpd_pkg::mode_t m, input logic [63:0] a,
		input logic [dmpd_pkg::SIZE_W-1:0] sz, input logic wr);
		dmpd_pkg::in_word_t w;
		w.mode = m;
		w.address = a;
		w.access_size = sz;
		w.is_write = wr;
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_shift(input logic [4:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_shift = v;
	endtask

	task automatic traffic(input int n);
		int                          cnt;
		int                          pick;
		int                          esh;
		int                          extra;
		int                          skip;
		logic [63:0]                 pg;
		logic [63:0]                 base;
		logic [63:0]                 pidx;
		logic [63:0]                 off;
		logic [63:0]                 addr;
		logic [63:0]                 eff;
		logic [dmpd_pkg::SIZE_W-1:0] sz;
		logic                        wr;
		cnt = 0;
		esh = (cur_shift < dmpd_pkg::MIN_SHIFT) ? int'(dmpd_pkg::MIN_SHIFT) :
			(cur_shift > dmpd_pkg::MAX_SHIFT) ? int'(dmpd_pkg::MAX_SHIFT) :
			int'(cur_shift);
		pg = 64'd1 << esh;
		while (cnt < n) begin
			base = hot_base[$urandom_range(3)];
			base = (base >> (esh + 7)) << (esh + 7);
			pidx = 64'($urandom_range(127));
			off = ($urandom_range(3) == 0) ? pg - 64'($urandom_range(16, 1)) :
				64'($urandom_range(32'(pg - 64'd1)));
			addr = base + (pidx << esh) + off;
			pick = int'($urandom_range(99));
			sz = (pick < 60) ? 13'($urandom_range(64)) :
				(pick < 90) ? 13'($urandom_range(4096)) : 13'($urandom_range(8191));
			wr = 1'($urandom_range(1));
			pick = int'($urandom_range(99));
			if (pick < 25) begin
				eff = (sz > dmpd_pkg::MAX_ACCESS) ? 64'(dmpd_pkg::MAX_ACCESS) : 64'(sz);
				extra = int'((off + eff) >> esh);
				skip = ($urandom_range(9) == 0) ? int'($urandom_range(32'(extra))) : -1;
				for (int i = 0; i <= extra; i++)
					if (i != skip)
						issue(dmpd_pkg::MODE_INSTALL, addr + 64'(i) * pg,
							13'($urandom_range(8191)), 1'($urandom_range(1)));
				issue(dmpd_pkg::MODE_DATA, addr, sz, wr);
				cnt += extra + 2;
			end else if (pick < 55) begin
				issue(dmpd_pkg::MODE_DATA, addr, sz, wr);
				cnt++;
			end else if (pick < 70) begin
				issue(dmpd_pkg::MODE_INSTALL, addr, sz, wr);
				cnt++;
			end else if (pick < 85) begin
				issue(dmpd_pkg::MODE_INSN, addr, sz, wr);
				cnt++;
			end else if (pick < 94) begin
				issue(dmpd_pkg::mode_t'(2'($urandom_range(2))), {$urandom, $urandom},
					13'($urandom_range(8191)), wr);
				cnt++;
			end else begin
				issue(dmpd_pkg::MODE_NONE, {$urandom, $urandom},
					13'($urandom_range(8191)), wr);
				cnt++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		snd_idle = 13;
		rcv_idle = 54;
		cur_shift = dmpd_pkg::RESET_SHIFT;
		hot_base[0] = '0;
		hot_base[1] = '1;
		hot_base[2] = {$urandom, $urandom};
		hot_base[3] = {$urandom, $urandom};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue(dmpd_pkg::MODE_DATA, 64'h0, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_INSTALL, 64'h123, 13'h1FFF, 1'b1);
		issue(dmpd_pkg::MODE_DATA, 64'h0, 13'd0, 1'b1);
		issue(dmpd_pkg::MODE_INSTALL, 64'h1000, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_DATA, 64'hFF0, 13'h20, 1'b1);
		issue(dmpd_pkg::MODE_DATA, 64'h1800, 13'd4096, 1'b0);
		issue(dmpd_pkg::MODE_INSTALL, 64'hFFFF_FFFF_FFFF_F000, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_DATA, 64'hFFFF_FFFF_FFFF_FFF8, 13'd16, 1'b1);
		issue(dmpd_pkg::MODE_INSTALL, 64'h2000, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_INSTALL, 64'h3ABC, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_DATA, 64'h2800, 13'h1FFF, 1'b1);
		issue(dmpd_pkg::MODE_INSN, 64'h2FFF, 13'h1FFF, 1'b1);
		issue(dmpd_pkg::MODE_INSN, 64'h1234_5678_9ABC_DEF1, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_NONE, 64'h5555_AAAA_5555_AAAA, 13'h0AAA, 1'b1);
		issue(dmpd_pkg::MODE_INSTALL, 64'h40000, 13'd0, 1'b0);
		issue(dmpd_pkg::MODE_DATA, 64'h0, 13'd1, 1'b0);
		issue(dmpd_pkg::MODE_DATA, 64'h40000, 13'd1, 1'b1);
		issue(dmpd_pkg::MODE_DATA, 64'hFFFF_FFFF_FFFF_FFFF, 13'd4096, 1'b1);
		issue(dmpd_pkg::MODE_INSN, 64'hFFFF_FFFF_FFFF_FFFF, 13'd0, 1'b1);
		issue(dmpd_pkg::MODE_INSTALL, 64'hAAAA_5555_AAAA_5555, 13'h1555, 1'b0);
		issue(dmpd_pkg::MODE_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 13'h1FFF, 1'b1);
		issue(dmpd_pkg::MODE_DATA, 64'hAAAA_5555_AAAA_5555, 13'h1555, 1'b0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			snd_idle = (p < 2) ? 13 : (p < 4) ? 54 : 0;
			rcv_idle = (p < 2) ? 54 : (p < 4) ? 13 : 0;
			write_shift(shift_plan[p]);
			traffic(PHASE_WORDS);
			drain();
		end

		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
